// ===== src/gn2d_pkg.sv =====
// Shared types, constants, easing table and blend function for the gradient noise block.
package gn2d_pkg;

  localparam int unsigned LATTICE_ENTRIES    = 4096;
  localparam int unsigned FRACTION_BITS      = 8;
  localparam int unsigned EASE_TABLE_ENTRIES = 256;

  localparam int unsigned LAT_AW   = $clog2(LATTICE_ENTRIES);
  localparam int unsigned EASE_AW  = $clog2(EASE_TABLE_ENTRIES);
  localparam int unsigned GIDX_W   = 12;
  localparam int unsigned PT_W     = 14;
  localparam int unsigned CELL_W   = PT_W - FRACTION_BITS;
  localparam int unsigned CFG_W    = 6;
  localparam int unsigned CIDX_W   = 2;
  localparam int unsigned OUT_FRAC = 12;
  localparam int unsigned NOISE_W  = 15;
  localparam int unsigned EASE_W   = 13;
  localparam int unsigned VAL_W    = 16;
  localparam int unsigned ROW_W    = 2 * CFG_W + 1;
  localparam int unsigned IDX_W    = ROW_W + 1;

  localparam logic [CIDX_W-1:0] REG_GRID_WIDTH  = 2'd0;
  localparam logic [CIDX_W-1:0] REG_GRID_HEIGHT = 2'd1;

  localparam longint unsigned PI_Q30 = 64'd3373259426;
  localparam longint unsigned TAYLOR_DIV [1:8] = '{12, 30, 56, 90, 132, 182, 240, 306};

  typedef logic [EASE_TABLE_ENTRIES-1:0][EASE_W-1:0] ease_rom_t;

  typedef struct packed {
    logic                             is_write;
    logic                             wr_ok;
    logic                             oor;
    logic [LAT_AW-1:0]                widx;
    logic [1:0]                       wgrad;
    logic [3:0][LAT_AW-1:0]           idx;
    logic [FRACTION_BITS-1:0]         fx;
    logic [FRACTION_BITS-1:0]         fy;
  } cmd_t;

  typedef struct packed {
    logic sample;
    logic oor;
    logic [FRACTION_BITS-1:0] fx;
    logic [FRACTION_BITS-1:0] fy;
  } meta_t;

  function automatic logic [EASE_W-1:0] ease_half(int unsigned k);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint unsigned sum;
    x    = (PI_Q30 * longint'(k)) / EASE_TABLE_ENTRIES;
    x2   = (x * x) >> 30;
    term = x2 >> 1;
    sum  = term;
    for (int n = 1; n <= 8; n++) begin
      term = ((term * x2) >> 30) / TAYLOR_DIV[n];
      if (n % 2 == 1) begin
        sum = sum - term;
      end else begin
        sum = sum + term;
      end
    end
    sum = sum >> 1;
    return EASE_W'((sum + (64'd1 << 17)) >> 18);
  endfunction

  function automatic ease_rom_t build_ease();
    ease_rom_t rom;
    for (int unsigned k = 0; k < EASE_TABLE_ENTRIES; k++) begin
      if (2 * k <= EASE_TABLE_ENTRIES) begin
        rom[k] = ease_half(k);
      end else begin
        rom[k] = EASE_W'(4096 - int'(ease_half(EASE_TABLE_ENTRIES - k)));
      end
    end
    return rom;
  endfunction

  localparam ease_rom_t EASE_ROM = build_ease();

  function automatic logic [EASE_W-1:0] ease_of(logic [FRACTION_BITS-1:0] f);
    logic [FRACTION_BITS+EASE_AW:0] t;
    logic [FRACTION_BITS+EASE_AW:0] s;
    t = (FRACTION_BITS + EASE_AW + 1)'(f) << EASE_AW;
    s = t >> FRACTION_BITS;
    return EASE_ROM[s[EASE_AW-1:0]];
  endfunction

  function automatic logic signed [VAL_W-1:0] blend(logic signed [VAL_W-1:0] a,
                                                   logic signed [VAL_W-1:0] b,
                                                   logic [FRACTION_BITS-1:0] f);
    logic signed [VAL_W:0]   diff;
    logic signed [30:0]      prod;
    logic signed [18:0]      q;
    logic signed [18:0]      r;
    diff = (VAL_W + 1)'(b) - (VAL_W + 1)'(a);
    prod = 31'(diff) * $signed({18'd0, ease_of(f)}) + 31'sd2048;
    q    = 19'(prod >>> 12);
    r    = 19'(a) + q;
    return r[VAL_W-1:0];
  endfunction

endpackage

// ===== src/gn2d_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module gn2d_ram #(
  parameter int unsigned WIDTH = 2,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== src/gn2d_front.sv =====
// Front end: takes input words, classifies them and works out corner indices.
module gn2d_front (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               push,
  output logic                               full,
  input  logic                               in_func,
  input  logic [gn2d_pkg::GIDX_W-1:0]        in_gradient_index,
  input  logic                               in_gradient_x_negative,
  input  logic                               in_gradient_y_negative,
  input  logic [gn2d_pkg::PT_W-1:0]          in_point_x,
  input  logic [gn2d_pkg::PT_W-1:0]          in_point_y,
  input  logic [gn2d_pkg::CFG_W-1:0]         grid_width,
  input  logic [gn2d_pkg::CFG_W-1:0]         grid_height,
  input  logic                               q_full,
  output logic                               q_push,
  output gn2d_pkg::cmd_t                     q_cmd
);
  import gn2d_pkg::*;

  cmd_t                 f_r;
  cmd_t                 f_nxt;
  logic                 f_vld_r;
  logic                 accept;
  logic [CELL_W-1:0]    cx;
  logic [CELL_W-1:0]    cy;
  logic [CFG_W:0]       stride;
  logic [ROW_W-1:0]     rowoff;
  logic [IDX_W-1:0]     base;
  logic [IDX_W-1:0]     idx3;

  assign accept = push && !full;
  assign full   = f_vld_r && q_full;
  assign q_push = f_vld_r && !q_full;
  assign q_cmd  = f_r;

  always_comb begin
    cx     = in_point_x[PT_W-1:FRACTION_BITS];
    cy     = in_point_y[PT_W-1:FRACTION_BITS];
    stride = (CFG_W + 1)'(grid_width) + 1'b1;
    rowoff = ROW_W'(cy) * ROW_W'(stride);
    base   = IDX_W'(rowoff) + IDX_W'(cx);
    idx3   = base + IDX_W'(stride) + 1'b1;
    f_nxt.is_write = !in_func;
    f_nxt.wr_ok    = (GIDX_W + 1)'(in_gradient_index) < (GIDX_W + 1)'(LATTICE_ENTRIES);
    f_nxt.widx     = LAT_AW'(in_gradient_index);
    f_nxt.wgrad    = {in_gradient_y_negative, in_gradient_x_negative};
    f_nxt.oor      = (cx >= grid_width) || (cy >= grid_height) ||
                     (idx3 >= IDX_W'(LATTICE_ENTRIES));
    f_nxt.idx[0]   = LAT_AW'(base);
    f_nxt.idx[1]   = LAT_AW'(base + 1'b1);
    f_nxt.idx[2]   = LAT_AW'(base + IDX_W'(stride));
    f_nxt.idx[3]   = LAT_AW'(idx3);
    f_nxt.fx       = in_point_x[FRACTION_BITS-1:0];
    f_nxt.fy       = in_point_y[FRACTION_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_vld_r <= 1'b0;
    end else begin
      f_vld_r <= accept || full;
    end
    if (accept) begin
      f_r <= f_nxt;
    end
  end

endmodule

// ===== src/gn2d_queue.sv =====
// Four-entry queue of classified commands between the front and back ends.
module gn2d_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  gn2d_pkg::cmd_t push_cmd,
  output logic           full,
  input  logic           pop,
  output logic           vld,
  output gn2d_pkg::cmd_t head
);
  import gn2d_pkg::*;

  cmd_t       store_r [4];
  logic [1:0] wp_r;
  logic [1:0] rp_r;
  logic [2:0] cnt_r;
  logic       do_pop;

  assign vld    = cnt_r != 3'd0;
  assign full   = cnt_r == 3'd4;
  assign head   = store_r[rp_r];
  assign do_pop = pop && vld;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 2'd0;
      rp_r  <= 2'd0;
      cnt_r <= 3'd0;
    end else begin
      if (push) begin
        wp_r <= wp_r + 2'd1;
      end
      if (do_pop) begin
        rp_r <= rp_r + 2'd1;
      end
      cnt_r <= cnt_r + 3'(push) - 3'(do_pop);
    end
    if (push) begin
      store_r[wp_r] <= push_cmd;
    end
  end

endmodule

// ===== src/gn2d_back.sv =====
// Back end: gradient lookups, corner dot products, easing blends and result queue.
module gn2d_back (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                q_vld,
  input  gn2d_pkg::cmd_t                      q_cmd,
  output logic                                q_pop,
  output logic signed [gn2d_pkg::NOISE_W-1:0] out_noise_value,
  output logic                                out_out_of_range,
  output logic                                empty,
  input  logic                                pop
);
  import gn2d_pkg::*;

  localparam int unsigned OQ_DEPTH = 8;
  localparam int unsigned DW       = OUT_FRAC + 2;

  logic                     issue;
  logic                     ram_we;
  logic [3:0][1:0]          grad;
  meta_t                    s1_r;
  meta_t                    s2_r;
  meta_t                    s3_r;
  logic                     s1_vld_r;
  logic                     s2_vld_r;
  logic                     s3_vld_r;
  logic signed [VAL_W-1:0]  dots_nxt [4];
  logic signed [VAL_W-1:0]  dots_r [4];
  logic signed [VAL_W-1:0]  top_r;
  logic signed [VAL_W-1:0]  bot_r;
  logic signed [VAL_W-1:0]  final_val;
  logic signed [DW-1:0]     dxa;
  logic signed [DW-1:0]     dya;
  logic signed [DW-1:0]     dx;
  logic signed [DW-1:0]     dy;
  logic signed [VAL_W-1:0]  vx;
  logic signed [VAL_W-1:0]  vy;
  logic [NOISE_W-1:0]       oq_val_r [OQ_DEPTH];
  logic                     oq_oor_r [OQ_DEPTH];
  logic [2:0]               oq_wp_r;
  logic [2:0]               oq_rp_r;
  logic [3:0]               oq_cnt_r;
  logic [3:0]               inflight;
  logic                     oq_pop;

  assign inflight = 4'(s1_vld_r) + 4'(s2_vld_r) + 4'(s3_vld_r);
  assign issue    = q_vld && ((oq_cnt_r + inflight) < 4'(OQ_DEPTH));
  assign q_pop    = issue;
  assign ram_we   = issue && q_cmd.is_write && q_cmd.wr_ok;

  for (genvar k = 0; k < 4; k++) begin : g_ram
    gn2d_ram #(
      .WIDTH (2),
      .DEPTH (LATTICE_ENTRIES)
    ) u_ram (
      .clk   (clk),
      .we    (ram_we),
      .waddr (q_cmd.widx),
      .wdata (q_cmd.wgrad),
      .raddr (q_cmd.idx[k]),
      .rdata (grad[k])
    );
  end

  always_comb begin
    dxa = DW'(s1_r.fx) <<< (OUT_FRAC - FRACTION_BITS);
    dya = DW'(s1_r.fy) <<< (OUT_FRAC - FRACTION_BITS);
    dx  = dxa;
    dy  = dya;
    vx  = '0;
    vy  = '0;
    for (int k = 0; k < 4; k++) begin
      dx = (k % 2 == 1) ? dxa - DW'(1 << OUT_FRAC) : dxa;
      dy = (k / 2 == 1) ? dya - DW'(1 << OUT_FRAC) : dya;
      vx = grad[k][0] ? -VAL_W'(dx) : VAL_W'(dx);
      vy = grad[k][1] ? -VAL_W'(dy) : VAL_W'(dy);
      dots_nxt[k] = vx + vy;
    end
  end

  assign final_val = blend(top_r, bot_r, s3_r.fy);
  assign oq_pop    = pop && !empty;
  assign empty     = oq_cnt_r == 4'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
      oq_wp_r  <= 3'd0;
      oq_rp_r  <= 3'd0;
      oq_cnt_r <= 4'd0;
    end else begin
      s1_vld_r <= issue;
      s2_vld_r <= s1_vld_r;
      s3_vld_r <= s2_vld_r;
      if (s3_vld_r) begin
        oq_wp_r <= oq_wp_r + 3'd1;
      end
      if (oq_pop) begin
        oq_rp_r <= oq_rp_r + 3'd1;
      end
      oq_cnt_r <= oq_cnt_r + 4'(s3_vld_r) - 4'(oq_pop);
    end
    s1_r.sample <= !q_cmd.is_write && !q_cmd.oor;
    s1_r.oor    <= !q_cmd.is_write && q_cmd.oor;
    s1_r.fx     <= q_cmd.fx;
    s1_r.fy     <= q_cmd.fy;
    s2_r        <= s1_r;
    dots_r      <= dots_nxt;
    s3_r        <= s2_r;
    top_r       <= blend(dots_r[0], dots_r[1], s2_r.fx);
    bot_r       <= blend(dots_r[2], dots_r[3], s2_r.fx);
    if (s3_vld_r) begin
      oq_val_r[oq_wp_r] <= s3_r.sample ? final_val[NOISE_W-1:0] : '0;
      oq_oor_r[oq_wp_r] <= s3_r.oor;
    end
  end

  assign out_noise_value  = oq_val_r[oq_rp_r];
  assign out_out_of_range = oq_oor_r[oq_rp_r];

endmodule

// ===== src/gradient_noise_2d.sv =====
// Top level of the two-dimensional gradient noise block.
// An accepted word passes the front-end register, the command queue, the lattice read with
// stage s1, then stages s2 and s3; its result then waits in the result queue for a pop.
// Throughput is one word per cycle while the result queue has room: the four corner
// gradients come from four copies of the lattice memory, each read at one corner index.
// Reset clears all queues and pipeline valids and sets both grid sizes to 63;
// lattice gradients are undefined until written.
module gradient_noise_2d (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                push,
  output logic                                full,
  input  logic                                in_func,
  input  logic [gn2d_pkg::GIDX_W-1:0]         in_gradient_index,
  input  logic                                in_gradient_x_negative,
  input  logic                                in_gradient_y_negative,
  input  logic [gn2d_pkg::PT_W-1:0]           in_point_x,
  input  logic [gn2d_pkg::PT_W-1:0]           in_point_y,
  output logic                                empty,
  input  logic                                pop,
  output logic signed [gn2d_pkg::NOISE_W-1:0] out_noise_value,
  output logic                                out_out_of_range,
  input  logic                                cfg_we,
  input  logic [gn2d_pkg::CIDX_W-1:0]         cfg_index,
  input  logic [gn2d_pkg::CFG_W-1:0]          cfg_data
);
  import gn2d_pkg::*;

  logic [CFG_W-1:0] grid_width_r;
  logic [CFG_W-1:0] grid_height_r;
  logic             q_full;
  logic             q_push;
  logic             q_pop;
  logic             q_vld;
  cmd_t             q_in;
  cmd_t             q_head;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_width_r  <= CFG_W'(63);
      grid_height_r <= CFG_W'(63);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_GRID_WIDTH:  grid_width_r  <= cfg_data;
        REG_GRID_HEIGHT: grid_height_r <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  gn2d_front u_front (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .push                   (push),
    .full                   (full),
    .in_func                (in_func),
    .in_gradient_index      (in_gradient_index),
    .in_gradient_x_negative (in_gradient_x_negative),
    .in_gradient_y_negative (in_gradient_y_negative),
    .in_point_x             (in_point_x),
    .in_point_y             (in_point_y),
    .grid_width             (grid_width_r),
    .grid_height            (grid_height_r),
    .q_full                 (q_full),
    .q_push                 (q_push),
    .q_cmd                  (q_in)
  );

  gn2d_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (q_in),
    .full     (q_full),
    .pop      (q_pop),
    .vld      (q_vld),
    .head     (q_head)
  );

  gn2d_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_vld            (q_vld),
    .q_cmd            (q_head),
    .q_pop            (q_pop),
    .out_noise_value  (out_noise_value),
    .out_out_of_range (out_out_of_range),
    .empty            (empty),
    .pop              (pop)
  );

  a_empty_after_reset: assert property (@(posedge clk)
    ($past(!rst_n) && rst_n) |-> empty)
    else $error("result queue not empty after reset");

  a_full_needs_queue_full: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> q_full)
    else $error("input stalled while the command queue has room");

  a_oor_gives_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_out_of_range) |-> (out_noise_value == '0))
    else $error("out of range result carries a non-zero value");

endmodule

// ===== dv/tb.sv =====
// Self-checking testbench for gradient_noise_2d: directed table, then randomised phases.
module tb;
  import gn2d_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic FUNC_WRITE  = 1'b0;
  localparam logic FUNC_SAMPLE = 1'b1;
  localparam logic [CIDX_W-1:0] REG_UNUSED = 2'd2;
  localparam int CYCLE_LIMIT = 600000;
  localparam int ITEMS_PER_PHASE = 60;

  typedef struct {
    logic [NOISE_W-1:0] value;
    logic               oor;
  } noise_word_t;

  typedef struct {
    logic               func;
    logic [GIDX_W-1:0]  gidx;
    logic               gxn;
    logic               gyn;
    logic [PT_W-1:0]    px;
    logic [PT_W-1:0]    py;
    bit                 typed;
    logic [NOISE_W-1:0] tvalue;
    logic               toor;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic push = 1'b0;
  logic full;
  logic in_func = FUNC_WRITE;
  logic [GIDX_W-1:0] in_gradient_index = '0;
  logic in_gradient_x_negative = 1'b0;
  logic in_gradient_y_negative = 1'b0;
  logic [PT_W-1:0] in_point_x = '0;
  logic [PT_W-1:0] in_point_y = '0;
  logic empty;
  logic pop = 1'b0;
  logic signed [NOISE_W-1:0] out_noise_value;
  logic out_out_of_range;
  logic cfg_we = 1'b0;
  logic [CIDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;

  gradient_noise_2d DUT (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  noise_word_t noise_expected[$];
  logic [1:0]  lattice [LATTICE_ENTRIES];
  bit          lattice_written [LATTICE_ENTRIES];
  int          ease_lut [EASE_TABLE_ENTRIES];
  int unsigned cells_across = 63;
  int unsigned cells_down = 63;
  int          errors = 0;
  int          cycles = 0;
  int          burst_left = 0;
  bit          push_on = 0;
  int          pop_rate = 100;
  int          pop_phase = 0;

  function automatic int ease_point(int unsigned k);
    longint unsigned x, x2, term, acc;
    x    = (64'd3373259426 * k) / EASE_TABLE_ENTRIES;
    x2   = (x * x) >> 30;
    term = x2 / 2;
    acc  = term;
    for (int n = 1; n <= 8; n++) begin
      term = ((term * x2) >> 30) / ((2 * n + 1) * (2 * n + 2));
      if (n % 2 == 1) begin
        acc = acc - term;
      end else begin
        acc = acc + term;
      end
    end
    acc = acc / 2;
    return int'((acc + (64'd1 << 17)) >> 18);
  endfunction

  function automatic int ease_mix(int a, int b, int f);
    int prod;
    prod = (b - a) * ease_lut[f] + 2048;
    return a + (prod >>> 12);
  endfunction

  function automatic noise_word_t noise_predict(stim_row_t w);
    noise_word_t res;
    int cx, cy, fx, fy, id, dx, dy, top, bottom;
    int dots [4];
    res.value = '0;
    res.oor   = 1'b0;
    if (w.func == FUNC_WRITE) begin
      lattice[w.gidx] = {w.gyn, w.gxn};
      lattice_written[w.gidx] = 1;
      return res;
    end
    cx = w.px >> FRACTION_BITS;
    cy = w.py >> FRACTION_BITS;
    fx = w.px & 8'hFF;
    fy = w.py & 8'hFF;
    if (cx >= cells_across || cy >= cells_down) begin
      res.oor = 1'b1;
      return res;
    end
    for (int j = 0; j < 2; j++) begin
      for (int i = 0; i < 2; i++) begin
        id = (cy + j) * (cells_across + 1) + cx + i;
        if (id >= LATTICE_ENTRIES) begin
          res.oor = 1'b1;
          return res;
        end
        dx = (fx - i * 256) * 16;
        dy = (fy - j * 256) * 16;
        dots[j * 2 + i] = (lattice[id][0] ? -dx : dx) + (lattice[id][1] ? -dy : dy);
      end
    end
    top    = ease_mix(dots[0], dots[1], fx);
    bottom = ease_mix(dots[2], dots[3], fx);
    res.value = NOISE_W'(ease_mix(top, bottom, fy));
    return res;
  endfunction

  task automatic send_word(stim_row_t w);
    noise_word_t res;
    push <= 1'b1;
    push_on = 1;
    in_func <= w.func;
    in_gradient_index <= w.gidx;
    in_gradient_x_negative <= w.gxn;
    in_gradient_y_negative <= w.gyn;
    in_point_x <= w.px;
    in_point_y <= w.py;
    do @(posedge clk); while (full);
    res = noise_predict(w);
    if (w.typed) begin
      res.value = w.tvalue;
      res.oor   = w.toor;
    end
    noise_expected.push_back(res);
    @(negedge clk);
    if (burst_left == 0) begin
      push <= 1'b0;
      push_on = 0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 10);
    end else begin
      burst_left--;
    end
  endtask

  task automatic send_write(int unsigned id);
    stim_row_t w;
    w = '{FUNC_WRITE, GIDX_W'(id), 1'($urandom), 1'($urandom),
          PT_W'($urandom), PT_W'($urandom), 0, '0, 1'b0};
    send_word(w);
  endtask

  task automatic send_sample(logic [PT_W-1:0] px, logic [PT_W-1:0] py);
    stim_row_t w;
    int cx, cy, id;
    cx = px >> FRACTION_BITS;
    cy = py >> FRACTION_BITS;
    if (cx < cells_across && cy < cells_down) begin
      for (int c = 0; c < 4; c++) begin
        id = (cy + c / 2) * (cells_across + 1) + cx + c % 2;
        if (id < LATTICE_ENTRIES && !lattice_written[id]) begin
          send_write(id);
        end
      end
    end
    w = '{FUNC_SAMPLE, GIDX_W'($urandom), 1'($urandom), 1'($urandom), px, py, 0, '0, 1'b0};
    send_word(w);
  endtask

  task automatic set_grid(int unsigned across, int unsigned down, bit poke_unused);
    if (push_on) begin
      push <= 1'b0;
      push_on = 0;
    end
    wait (noise_expected.size() == 0);
    repeat (10) @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= REG_GRID_WIDTH;
    cfg_data <= CFG_W'(across);
    @(negedge clk);
    cfg_index <= REG_GRID_HEIGHT;
    cfg_data <= CFG_W'(down);
    if (poke_unused) begin
      @(negedge clk);
      cfg_index <= REG_UNUSED;
      cfg_data <= '1;
    end
    @(negedge clk);
    cfg_we <= 1'b0;
    cells_across = across;
    cells_down = down;
  endtask

  always @(negedge clk) begin
    if (rst_n) begin
      pop_phase <= pop_phase + 1;
      if (pop_phase % 150 == 0) begin
        case ($urandom_range(0, 3))
          0: pop_rate <= 100;
          1: pop_rate <= 70;
          2: pop_rate <= 30;
          default: pop_rate <= 5;
        endcase
      end
      pop <= ($urandom_range(0, 99) < pop_rate);
    end
  end

  always @(posedge clk) begin
    noise_word_t exp_word;
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
    if (rst_n && pop && !empty) begin
      if (noise_expected.size() == 0) begin
        errors++;
        if (errors <= 10) begin
          $display("Unexpected word: noise %0d, out of range %0b",
                   out_noise_value, out_out_of_range);
        end
      end else begin
        exp_word = noise_expected.pop_front();
        if (out_noise_value !== exp_word.value || out_out_of_range !== exp_word.oor) begin
          errors++;
          if (errors <= 10) begin
            $display("Mismatch: expected noise %0d oor %0b, got noise %0d oor %0b",
                     $signed(exp_word.value), exp_word.oor, out_noise_value,
                     out_out_of_range);
          end
        end
      end
    end
  end

  stim_row_t directed [] = '{
    '{FUNC_WRITE,  12'd0,    1'b0, 1'b0, 14'd0, 14'd0, 1, 15'd0, 1'b0},
    '{FUNC_WRITE,  12'd1,    1'b1, 1'b0, 14'd0, 14'd0, 1, 15'd0, 1'b0},
    '{FUNC_WRITE,  12'd64,   1'b0, 1'b1, 14'd0, 14'd0, 1, 15'd0, 1'b0},
    '{FUNC_WRITE,  12'd65,   1'b1, 1'b1, 14'd0, 14'd0, 1, 15'd0, 1'b0},
    '{FUNC_SAMPLE, 12'd0,    1'b0, 1'b0, 14'h0000, 14'h0000, 0, 15'd0, 1'b0},
    '{FUNC_SAMPLE, 12'd0,    1'b0, 1'b0, 14'h00FF, 14'h00FF, 0, 15'd0, 1'b0},
    '{FUNC_SAMPLE, 12'd0,    1'b0, 1'b0, 14'h0080, 14'h0040, 0, 15'd0, 1'b0},
    '{FUNC_SAMPLE, 12'd0,    1'b0, 1'b0, 14'h00FF, 14'h0000, 0, 15'd0, 1'b0},
    '{FUNC_WRITE,  12'd4095, 1'b1, 1'b1, 14'h3FFF, 14'h3FFF, 1, 15'd0, 1'b0},
    '{FUNC_WRITE,  12'd4094, 1'b0, 1'b1, 14'd0, 14'd0, 1, 15'd0, 1'b0},
    '{FUNC_WRITE,  12'd4031, 1'b1, 1'b0, 14'd0, 14'd0, 1, 15'd0, 1'b0},
    '{FUNC_WRITE,  12'd4030, 1'b0, 1'b0, 14'd0, 14'd0, 1, 15'd0, 1'b0},
    '{FUNC_SAMPLE, 12'd0,    1'b0, 1'b0, 14'h3EFF, 14'h3EFF, 0, 15'd0, 1'b0},
    '{FUNC_SAMPLE, 12'd0,    1'b0, 1'b0, 14'h3E00, 14'h3E80, 0, 15'd0, 1'b0},
    '{FUNC_SAMPLE, 12'd4095, 1'b1, 1'b1, 14'h3FFF, 14'h0000, 1, 15'd0, 1'b1},
    '{FUNC_SAMPLE, 12'd0,    1'b0, 1'b0, 14'h0000, 14'h3FFF, 1, 15'd0, 1'b1},
    '{FUNC_SAMPLE, 12'd0,    1'b0, 1'b0, 14'h3FFF, 14'h3FFF, 1, 15'd0, 1'b1},
    '{FUNC_WRITE,  12'd2048, 1'b1, 1'b0, 14'd0, 14'd0, 1, 15'd0, 1'b0},
    '{FUNC_WRITE,  12'd2047, 1'b0, 1'b1, 14'd0, 14'd0, 1, 15'd0, 1'b0}
  };

  int phase_across [8] = '{63, 1, 63, 1, 0, 37, 0, 63};
  int phase_down   [8] = '{63, 1, 1, 63, 5, 50, 0, 63};

  initial begin
    int r, n_items;
    for (int k = 0; k < EASE_TABLE_ENTRIES; k++) begin
      ease_lut[k] = (2 * k <= EASE_TABLE_ENTRIES) ? ease_point(k)
                                                  : 4096 - ease_point(EASE_TABLE_ENTRIES - k);
    end
    phase_across[6] = $urandom_range(2, 62);
    phase_down[6]   = $urandom_range(2, 62);
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    foreach (directed[i]) begin
      send_word(directed[i]);
    end
    for (int p = 0; p < 8; p++) begin
      set_grid(phase_across[p], phase_down[p], p == 3);
      n_items = (phase_across[p] == 0) ? 20 : ITEMS_PER_PHASE;
      for (int i = 0; i < n_items; i++) begin
        r = $urandom_range(0, 99);
        if (r < 20) begin
          send_write($urandom_range(0, LATTICE_ENTRIES - 1));
        end else if (r < 32 || cells_across == 0 || cells_down == 0) begin
          send_sample(PT_W'($urandom_range(0, 16383)), PT_W'($urandom_range(0, 16383)));
        end else begin
          send_sample({CELL_W'($urandom_range(0, cells_across - 1)), 8'($urandom)},
                      {CELL_W'($urandom_range(0, cells_down - 1)), 8'($urandom)});
        end
      end
    end
    if (push_on) begin
      push <= 1'b0;
      push_on = 0;
    end
    wait (noise_expected.size() == 0);
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/gn2d_pkg.sv
src/gn2d_ram.sv
src/gn2d_front.sv
src/gn2d_queue.sv
src/gn2d_back.sv
src/gradient_noise_2d.sv
dv/tb.sv
